/* sv/imu_cs_pkg.sv */
package imu_cs_pkg;

  localparam int CALIB_WORDS = 17;
  localparam int IDX_W       = 5;
  localparam int SAMPLE_W    = 16;
  localparam int AXIS_W      = 3;
  localparam int VAL_W       = 32;
  localparam int RES_W       = 17;  // resolution constants up to 65536

  localparam int SX_W    = 34;  // signed sensitivity numerator
  localparam int SXMAG_W = 33;
  localparam int D_W     = 17;  // signed denominator
  localparam int DMAG_W  = 16;
  localparam int M_W     = 19;  // signed bias-removed sample
  localparam int Q_W     = SXMAG_W + 1;
  localparam int R_W     = DMAG_W + 1;
  localparam int QM_W    = Q_W + M_W;
  localparam int RM_W    = R_W + M_W;
  localparam int RMMAG_W = 34;
  localparam int SUM_W   = QM_W + 1;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [AXIS_W-1:0] AXIS_ACC_X     = 3'd0;
  localparam logic [AXIS_W-1:0] AXIS_ACC_Y     = 3'd1;
  localparam logic [AXIS_W-1:0] AXIS_ACC_Z     = 3'd2;
  localparam logic [AXIS_W-1:0] AXIS_GYRO_P    = 3'd3;
  localparam logic [AXIS_W-1:0] AXIS_GYRO_Y    = 3'd4;
  localparam logic [AXIS_W-1:0] AXIS_GYRO_R    = 3'd5;

  localparam int W_BIAS_P    = 0;
  localparam int W_BIAS_Y    = 1;
  localparam int W_BIAS_R    = 2;
  localparam int W_P_PLUS    = 3;
  localparam int W_P_MINUS   = 4;
  localparam int W_Y_PLUS    = 5;
  localparam int W_Y_MINUS   = 6;
  localparam int W_R_PLUS    = 7;
  localparam int W_R_MINUS   = 8;
  localparam int W_SPD_PLUS  = 9;
  localparam int W_SPD_MINUS = 10;
  localparam int W_AX_PLUS   = 11;
  localparam int W_AX_MINUS  = 12;
  localparam int W_AY_PLUS   = 13;
  localparam int W_AY_MINUS  = 14;
  localparam int W_AZ_PLUS   = 15;
  localparam int W_AZ_MINUS  = 16;

  typedef struct packed {
    logic [AXIS_W-1:0]      axis;
    logic signed [SX_W-1:0] sx;
    logic signed [D_W-1:0]  d;
    logic signed [M_W-1:0]  m;
  } job_t;

  typedef struct packed {
    logic signed [M_W-1:0] m;
    logic [AXIS_W-1:0]     axis;
    logic                  err;
    logic                  sx_neg;
    logic                  d_neg;
  } sb1_t;

  typedef struct packed {
    logic signed [QM_W-1:0] qm;
    logic [AXIS_W-1:0]      axis;
    logic                   err;
    logic                   neg;
  } sb2_t;

endpackage

/* sv/imu_cs_if.sv */
interface imu_cs_in_if;
  import imu_cs_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [IDX_W-1:0]           calib_index;
  logic signed [SAMPLE_W-1:0] calib_value;
  logic [AXIS_W-1:0]          axis;
  logic signed [SAMPLE_W-1:0] raw_sample;

  modport source (output valid, operation, calib_index, calib_value, axis, raw_sample,
                  input ready);
  modport sink (input valid, operation, calib_index, calib_value, axis, raw_sample,
                output ready);
endinterface

interface imu_cs_out_if;
  import imu_cs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [AXIS_W-1:0]       axis_out;
  logic signed [VAL_W-1:0] calibrated_value;
  logic                    divide_error;

  modport source (output valid, axis_out, calibrated_value, divide_error, input ready);
  modport sink (input valid, axis_out, calibrated_value, divide_error, output ready);
endinterface

/* sv/imu_cs_front.sv */
module imu_cs_front #(
  parameter int GYRO_RES_PER_DEG = 1024,
  parameter int ACCEL_RES_PER_G  = 8192
) (
  input  logic               clk,
  imu_cs_in_if.sink          in_ch,
  input  logic               q_ready,
  output logic               q_push,
  output imu_cs_pkg::job_t   q_job
);
  import imu_cs_pkg::*;

  localparam logic [RES_W-1:0] GYRO_K = RES_W'(GYRO_RES_PER_DEG);
  localparam logic [SX_W-1:0]  ACC_SX = SX_W'(2 * ACCEL_RES_PER_G);

  logic signed [SAMPLE_W-1:0] words_r [CALIB_WORDS];
  logic                       accept;
  logic                       is_acc;
  logic signed [SAMPLE_W-1:0] plus, minus, gbias;
  logic signed [D_W-1:0]      range, rsum, half, spd;
  logic signed [M_W-1:0]      bias;
  logic signed [RES_W:0]      gk;
  logic signed [D_W+RES_W:0]  gprod;

  assign in_ch.ready = q_ready;
  assign accept      = in_ch.valid && q_ready;

  // Store loads; indexes past the last word drop silently.
  always_ff @(posedge clk) begin
    if (accept && in_ch.operation == OP_LOAD && in_ch.calib_index < IDX_W'(CALIB_WORDS)) begin
      words_r[in_ch.calib_index] <= in_ch.calib_value;
    end
  end

  always_comb begin
    plus  = '0;
    minus = '0;
    gbias = '0;
    unique case (in_ch.axis)
      AXIS_ACC_X:  begin plus = words_r[W_AX_PLUS]; minus = words_r[W_AX_MINUS]; end
      AXIS_ACC_Y:  begin plus = words_r[W_AY_PLUS]; minus = words_r[W_AY_MINUS]; end
      AXIS_ACC_Z:  begin plus = words_r[W_AZ_PLUS]; minus = words_r[W_AZ_MINUS]; end
      AXIS_GYRO_P: begin
        plus = words_r[W_P_PLUS]; minus = words_r[W_P_MINUS]; gbias = words_r[W_BIAS_P];
      end
      AXIS_GYRO_Y: begin
        plus = words_r[W_Y_PLUS]; minus = words_r[W_Y_MINUS]; gbias = words_r[W_BIAS_Y];
      end
      AXIS_GYRO_R: begin
        plus = words_r[W_R_PLUS]; minus = words_r[W_R_MINUS]; gbias = words_r[W_BIAS_R];
      end
      default: ;
    endcase
  end

  always_comb begin
    is_acc = in_ch.axis <= AXIS_ACC_Z;
    range  = {plus[SAMPLE_W-1], plus} - {minus[SAMPLE_W-1], minus};
    // halve toward zero
    rsum   = range + {{(D_W-1){1'b0}}, range[D_W-1]};
    half   = {rsum[D_W-1], rsum[D_W-1:1]};
    if (is_acc) begin
      bias = M_W'(plus) - M_W'(half);
    end else begin
      bias = M_W'(gbias);
    end
    spd   = {words_r[W_SPD_PLUS][SAMPLE_W-1], words_r[W_SPD_PLUS]} +
            {words_r[W_SPD_MINUS][SAMPLE_W-1], words_r[W_SPD_MINUS]};
    gk    = {1'b0, GYRO_K};
    gprod = spd * gk;
  end

  assign q_push   = accept && in_ch.operation == OP_SAMPLE && in_ch.axis <= AXIS_GYRO_R;
  assign q_job.axis = in_ch.axis;
  assign q_job.sx   = is_acc ? $signed(ACC_SX) : gprod[SX_W-1:0];
  assign q_job.d    = range;
  assign q_job.m    = M_W'(in_ch.raw_sample) - bias;

endmodule

/* sv/imu_cs_queue.sv */
module imu_cs_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  imu_cs_pkg::job_t push_job,
  output logic             push_ready,
  input  logic             pop,
  output logic             pop_valid,
  output imu_cs_pkg::job_t pop_job
);
  import imu_cs_pkg::*;

  job_t       ent_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;
  logic       do_pop;

  assign push_ready = cnt_r != 2'd2;
  assign pop_valid  = cnt_r != 2'd0;
  assign pop_job    = ent_r[rd_r];
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (do_pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_r] <= push_job;
  end

endmodule

/* sv/imu_cs_div.sv */
module imu_cs_div #(
  parameter int NUM_W = 33,
  parameter int DEN_W = 16,
  parameter int SB_W  = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [SB_W-1:0]  sb,
  output logic             out_valid,
  output logic [NUM_W-1:0] quo,
  output logic [DEN_W-1:0] rem,
  output logic [DEN_W-1:0] den_out,
  output logic [SB_W-1:0]  sb_out
);

  logic             v_r  [NUM_W];
  logic [DEN_W-1:0] r_r  [NUM_W];
  logic [NUM_W-1:0] n_r  [NUM_W];
  logic [DEN_W-1:0] d_r  [NUM_W];
  logic [SB_W-1:0]  sb_r [NUM_W];

  // One quotient bit per stage, restoring.
  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic             v_src;
    logic [DEN_W-1:0] r_src, d_src, r_nxt;
    logic [NUM_W-1:0] n_src, n_nxt;
    logic [SB_W-1:0]  sb_src;
    logic [DEN_W:0]   t, diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign v_src  = in_valid;
      assign r_src  = '0;
      assign n_src  = num;
      assign d_src  = den;
      assign sb_src = sb;
    end else begin : g_next
      assign v_src  = v_r[k-1];
      assign r_src  = r_r[k-1];
      assign n_src  = n_r[k-1];
      assign d_src  = d_r[k-1];
      assign sb_src = sb_r[k-1];
    end

    always_comb begin
      t     = {r_src, n_src[NUM_W-1]};
      diff  = t - {1'b0, d_src};
      ge    = t >= {1'b0, d_src};
      r_nxt = ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
      n_nxt = {n_src[NUM_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k]  <= r_nxt;
        n_r[k]  <= n_nxt;
        d_r[k]  <= d_src;
        sb_r[k] <= sb_src;
      end
    end
  end

  assign out_valid = v_r[NUM_W-1];
  assign quo       = n_r[NUM_W-1];
  assign rem       = r_r[NUM_W-1];
  assign den_out   = d_r[NUM_W-1];
  assign sb_out    = sb_r[NUM_W-1];

endmodule

/* sv/imu_cs_back.sv */
module imu_cs_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  imu_cs_pkg::job_t q_job,
  output logic             q_pop,
  imu_cs_out_if.source     out_ch
);
  import imu_cs_pkg::*;

  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(64'sd2147483648);

  logic adv;

  // s0: magnitudes and signs
  logic               s0_v_r;
  logic [SXMAG_W-1:0] s0_ax_r;
  logic [DMAG_W-1:0]  s0_ad_r;
  sb1_t               s0_sb_r;
  logic [SX_W-1:0]    sx_abs;
  logic [D_W-1:0]     d_abs;

  // first divide
  logic               d1_v;
  logic [SXMAG_W-1:0] d1_q;
  logic [DMAG_W-1:0]  d1_r, d1_d;
  logic [$bits(sb1_t)-1:0] d1_sb_raw;
  sb1_t               d1_sb;

  // s2: signed q, r and the two products
  logic                   s2_v_r;
  logic signed [QM_W-1:0] s2_qm_r;
  logic signed [RM_W-1:0] s2_rm_r;
  logic [DMAG_W-1:0]      s2_ad_r;
  logic [AXIS_W-1:0]      s2_axis_r;
  logic                   s2_err_r, s2_dneg_r;
  logic signed [Q_W-1:0]  q_s;
  logic signed [R_W-1:0]  r_s;
  logic [RM_W-1:0]        rm_abs;
  sb2_t                   s2_sb;

  // second divide
  logic               d2_v;
  logic [RMMAG_W-1:0] d2_q;
  logic [DMAG_W-1:0]  d2_r, d2_d;
  logic [$bits(sb2_t)-1:0] d2_sb_raw;
  sb2_t               d2_sb;

  logic signed [RMMAG_W:0]  q2_s;
  logic signed [SUM_W-1:0]  sum;
  logic signed [VAL_W-1:0]  val;

  logic                    ov_r;
  logic [AXIS_W-1:0]       oaxis_r;
  logic signed [VAL_W-1:0] oval_r;
  logic                    oerr_r;

  assign adv   = !ov_r || out_ch.ready;
  assign q_pop = adv;

  always_comb begin
    sx_abs = q_job.sx[SX_W-1] ? -q_job.sx : q_job.sx;
    d_abs  = q_job.d[D_W-1] ? -q_job.d : q_job.d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s0_v_r <= 1'b0;
    else if (adv) s0_v_r <= q_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_ax_r        <= sx_abs[SXMAG_W-1:0];
      s0_ad_r        <= d_abs[DMAG_W-1:0];
      s0_sb_r.m      <= q_job.m;
      s0_sb_r.axis   <= q_job.axis;
      s0_sb_r.err    <= q_job.d == '0;
      s0_sb_r.sx_neg <= q_job.sx[SX_W-1];
      s0_sb_r.d_neg  <= q_job.d[D_W-1];
    end
  end

  imu_cs_div #(.NUM_W(SXMAG_W), .DEN_W(DMAG_W), .SB_W($bits(sb1_t))) u_div1 (
    .clk, .rst_n, .en(adv), .in_valid(s0_v_r), .num(s0_ax_r), .den(s0_ad_r),
    .sb(s0_sb_r), .out_valid(d1_v), .quo(d1_q), .rem(d1_r), .den_out(d1_d),
    .sb_out(d1_sb_raw)
  );
  assign d1_sb = sb1_t'(d1_sb_raw);

  always_comb begin
    q_s = (d1_sb.sx_neg ^ d1_sb.d_neg) ? -$signed({1'b0, d1_q}) : $signed({1'b0, d1_q});
    r_s = d1_sb.sx_neg ? -$signed({1'b0, d1_r}) : $signed({1'b0, d1_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (adv) s2_v_r <= d1_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_qm_r   <= q_s * d1_sb.m;
      s2_rm_r   <= r_s * d1_sb.m;
      s2_ad_r   <= d1_d;
      s2_axis_r <= d1_sb.axis;
      s2_err_r  <= d1_sb.err;
      s2_dneg_r <= d1_sb.d_neg;
    end
  end

  always_comb begin
    rm_abs      = s2_rm_r[RM_W-1] ? -s2_rm_r : s2_rm_r;
    s2_sb.qm    = s2_qm_r;
    s2_sb.axis  = s2_axis_r;
    s2_sb.err   = s2_err_r;
    s2_sb.neg   = s2_rm_r[RM_W-1] ^ s2_dneg_r;
  end

  imu_cs_div #(.NUM_W(RMMAG_W), .DEN_W(DMAG_W), .SB_W($bits(sb2_t))) u_div2 (
    .clk, .rst_n, .en(adv), .in_valid(s2_v_r), .num(rm_abs[RMMAG_W-1:0]), .den(s2_ad_r),
    .sb(s2_sb), .out_valid(d2_v), .quo(d2_q), .rem(d2_r), .den_out(d2_d),
    .sb_out(d2_sb_raw)
  );
  assign d2_sb = sb2_t'(d2_sb_raw);

  always_comb begin
    q2_s = d2_sb.neg ? -$signed({1'b0, d2_q}) : $signed({1'b0, d2_q});
    sum  = SUM_W'(d2_sb.qm) + SUM_W'(q2_s);
    if (d2_sb.err) val = '0;
    else if (sum > SAT_MAX) val = SAT_MAX[VAL_W-1:0];
    else if (sum < SAT_MIN) val = SAT_MIN[VAL_W-1:0];
    else val = sum[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (adv) ov_r <= d2_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      oaxis_r <= d2_sb.axis;
      oval_r  <= val;
      oerr_r  <= d2_sb.err;
    end
  end

  assign out_ch.valid            = ov_r;
  assign out_ch.axis_out         = oaxis_r;
  assign out_ch.calibrated_value = oval_r;
  assign out_ch.divide_error     = oerr_r;

  // remainder and echoed denominator of the second divide are unused
  logic unused_bits;
  assign unused_bits = ^{d2_r, d2_d};

endmodule

/* sv/imu_calibrated_sample_scaler_unit.sv */
// A sample request passes the queue, the prep register, a 33-stage divide, the product
// register, a 34-stage divide and the output register. Throughput: one request per cycle
// unless out_ch stalls; the two bit-per-stage dividers are fully pipelined.
// Load requests take effect for the next accepted request and give no result.
// Reset (rst_n, synchronous, active low) empties the queue and all stage valids;
// calibration words hold no reset value and must be loaded before use.
module imu_calibrated_sample_scaler_unit #(
  parameter int GYRO_RES_PER_DEG = 1024,
  parameter int ACCEL_RES_PER_G  = 8192
) (
  input logic          clk,
  input logic          rst_n,
  imu_cs_in_if.sink    in_ch,
  imu_cs_out_if.source out_ch
);
  import imu_cs_pkg::*;

  // Front to back queue.
  logic q_push, q_ready, q_pop, q_valid;
  job_t push_job, pop_job;

  // Front: store loads, select words, form numerator, denominator and offset sample.
  imu_cs_front #(
    .GYRO_RES_PER_DEG(GYRO_RES_PER_DEG),
    .ACCEL_RES_PER_G (ACCEL_RES_PER_G)
  ) u_front (
    .clk, .in_ch, .q_ready, .q_push, .q_job(push_job)
  );

  // Two entries: hold the front while the back stalls.
  imu_cs_queue u_queue (
    .clk, .rst_n, .push(q_push), .push_job, .push_ready(q_ready),
    .pop(q_pop), .pop_valid(q_valid), .pop_job
  );

  // Back: split divide, products, saturate, drive the output register.
  imu_cs_back u_back (
    .clk, .rst_n, .q_valid, .q_job(pop_job), .q_pop, .out_ch
  );

endmodule
